FILE: design/bjp_pkg.sv
// shared constants, types and codes for the block jump pointer table
package bjp_pkg;

  // table geometry
  localparam int MAX_HOLES  = 1024;
  localparam int BLOCK_SIZE = 32;

  // item field width and derived widths
  localparam int FIELD_W   = 11;
  localparam int FIELD_MAX = (1 << FIELD_W) - 1;
  localparam int ADDR_W    = $clog2(MAX_HOLES);
  localparam int POS_W     = $clog2(MAX_HOLES + 1);
  localparam int JUMPS_W   = $clog2(BLOCK_SIZE + 1);
  localparam int STEP_W    = $clog2(MAX_HOLES + 1);
  localparam int V_W       = $clog2(MAX_HOLES + (1 << FIELD_W));
  localparam int CMP_W     = (FIELD_W > POS_W) ? FIELD_W : POS_W;

  // hole_count after reset
  localparam logic [FIELD_W-1:0] HOLE_COUNT_RST = FIELD_W'(1024);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request type codes
  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // classified command
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_QUERY = 2'd1,
    OP_ECHO  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] str;
  } cmd_t;

  // per-position shortcut inside a block
  typedef struct packed {
    logic [ADDR_W-1:0]  exit_pos;
    logic [JUMPS_W-1:0] jumps;
    logic [POS_W-1:0]   next_pos;
  } shortcut_t;

  localparam int SC_W = $bits(shortcut_t);

  // how a rebuilt entry leaves its block
  typedef enum logic [1:0] {
    SK_EXIT  = 2'd0,
    SK_CHAIN = 2'd1,
    SK_CROSS = 2'd2
  } sc_kind_t;

endpackage

FILE: design/bjp_ifs.sv
// valid/ready channel interfaces for request and result items
interface bjp_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bjp_pkg::FIELD_W-1:0] position;
  logic [bjp_pkg::FIELD_W-1:0] strength;

  modport source (output valid, req_type, position, strength, input ready);
  modport sink   (input valid, req_type, position, strength, output ready);
endinterface

interface bjp_out_if;
  logic                        valid;
  logic                        ready;
  logic [bjp_pkg::FIELD_W-1:0] last_hole;
  logic [bjp_pkg::FIELD_W-1:0] jump_count;

  modport source (output valid, last_hole, jump_count, input ready);
  modport sink   (input valid, last_hole, jump_count, output ready);
endinterface

FILE: design/block_jump_pointer_table_unit.sv
// Jump pointer table over up to 1024 positions, split into blocks of 32 with
// per-position shortcuts (exit position, jumps to leave the block, landing).
// Request items go through a classifier and a two-entry command queue to a
// sequencer that owns the strength memory and the shortcut memory, so the
// input keeps taking items while the sequencer works, until the queue is
// full. A set rebuilds each entry from the position down to its block start
// with a read-then-write loop on the shortcut memory. A query follows one
// shortcut after another, at most 1024 for a walk, on the shortcut memory's
// read port. An out of range query skips the walk; an out of range set is
// dropped at the input. Memories need no clearing pass: every position must
// be written before it is queried. hole_count is to be written by the user
// only while the block is idle; the block itself does not enforce this. Its
// active value is clamped to 1..1024.
module block_jump_pointer_table_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  bjp_in_if.sink                      in_chan,
  bjp_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [bjp_pkg::FIELD_W-1:0] cfg_wdata
);
  import bjp_pkg::*;

  logic [FIELD_W-1:0] hole_count_r;
  logic [POS_W-1:0]   n_eff;
  logic               push_valid;
  logic               push_ready;
  cmd_t               push_cmd;
  logic               pop_valid;
  logic               pop_ready;
  cmd_t               pop_cmd;

  // hole_count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_count_r <= HOLE_COUNT_RST;
    end else if (cfg_we) begin
      hole_count_r <= cfg_wdata;
    end
  end

  // active count clamped to 1..MAX_HOLES
  always_comb begin
    if (hole_count_r == '0) begin
      n_eff = POS_W'(1);
    end else if (CMP_W'(hole_count_r) > CMP_W'(MAX_HOLES)) begin
      n_eff = POS_W'(MAX_HOLES);
    end else begin
      n_eff = POS_W'(hole_count_r);
    end
  end

  bjp_front u_front (
    .n_eff      (n_eff),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  bjp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  bjp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_eff     (n_eff),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_chan  (out_chan)
  );

endmodule

FILE: design/bjp_ram.sv
// generic single write port, single read port ram with registered read
module bjp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/bjp_front.sv
// front end: accepts request items, range checks and classifies them
module bjp_front (
  input  logic [bjp_pkg::POS_W-1:0] n_eff,
  bjp_in_if.sink                    in_chan,
  output logic                      push_valid,
  input  logic                      push_ready,
  output bjp_pkg::cmd_t             push_cmd
);
  import bjp_pkg::*;

  logic oor;

  // position zero or beyond the active count is out of range
  assign oor = (in_chan.position == '0) ||
               (CMP_W'(in_chan.position) > CMP_W'(n_eff));

  assign in_chan.ready = push_ready;

  // out of range sets are dropped here, everything else goes to the queue
  always_comb begin
    push_cmd.pos = in_chan.position;
    push_cmd.str = (in_chan.strength == '0) ? FIELD_W'(1) : in_chan.strength;
    push_valid   = in_chan.valid;
    unique case (in_chan.req_type)
      REQ_SET: begin
        push_cmd.op = OP_SET;
        if (oor) begin
          push_valid = 1'b0;
        end
      end
      REQ_QUERY: begin
        push_cmd.op = oor ? OP_ECHO : OP_QUERY;
      end
      default: begin
        push_cmd.op = OP_ECHO;
      end
    endcase
  end

endmodule

FILE: design/bjp_queue.sv
// short command queue between front end and back end
module bjp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  bjp_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output bjp_pkg::cmd_t pop_cmd
);
  import bjp_pkg::*;

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

FILE: design/bjp_back.sv
// back end: rebuilds shortcuts on sets and walks them on queries
module bjp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bjp_pkg::POS_W-1:0] n_eff,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  bjp_pkg::cmd_t             cmd,
  bjp_out_if.source                 out_chan
);
  import bjp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RB_A = 6'b000010,
    S_RB_B = 6'b000100,
    S_QRUN = 6'b001000,
    S_DONE = 6'b010000,
    S_SPARE = 6'b100000
  } back_state_t;

  back_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0]  i_r, i_nxt;
  logic [FIELD_W-1:0] str_r, str_nxt;
  logic               first_r, first_nxt;
  logic [V_W-1:0]     v_r, v_nxt;
  sc_kind_t           kind_r, kind_nxt;
  logic [FIELD_W-1:0] sum_r, sum_nxt;
  logic [STEP_W-1:0]  steps_r, steps_nxt;
  logic [FIELD_W-1:0] res_last_r, res_last_nxt;
  logic [FIELD_W-1:0] res_jumps_r, res_jumps_nxt;
  logic               out_valid_r;
  logic [FIELD_W-1:0] out_last_r;
  logic [FIELD_W-1:0] out_jumps_r;
  logic               out_load;

  logic               str_we;
  logic [ADDR_W-1:0]  str_waddr;
  logic [FIELD_W-1:0] str_wdata;
  logic [ADDR_W-1:0]  str_raddr;
  logic [FIELD_W-1:0] str_q;
  logic               sc_we;
  logic [ADDR_W-1:0]  sc_waddr;
  shortcut_t          sc_wdata;
  logic [ADDR_W-1:0]  sc_raddr;
  shortcut_t          sc_q;

  logic [ADDR_W-1:0]  cmd_addr;
  logic [FIELD_W-1:0] s_cur;
  logic [V_W-1:0]     v_cur;
  sc_kind_t           kind_cur;
  logic [FIELD_W:0]   sum_ext;
  logic [FIELD_W-1:0] sum_sat;
  logic               walk_more;

  // strength and shortcut memories
  bjp_ram #(.WIDTH(FIELD_W), .DEPTH(MAX_HOLES)) u_str_ram (
    .clk   (clk),
    .we    (str_we),
    .waddr (str_waddr),
    .wdata (str_wdata),
    .raddr (str_raddr),
    .rdata (str_q)
  );

  bjp_ram #(.WIDTH(SC_W), .DEPTH(MAX_HOLES)) u_sc_ram (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_q)
  );

  assign cmd_addr = ADDR_W'(cmd.pos - 1'b1);

  // landing of the jump from the entry being rebuilt
  assign s_cur = first_r ? str_r : str_q;
  assign v_cur = V_W'(i_r) + V_W'(s_cur);

  always_comb begin
    if (v_cur >= V_W'(n_eff)) begin
      kind_cur = SK_EXIT;
    end else if ((v_cur[ADDR_W-1:0] / BLOCK_SIZE) == (i_r / BLOCK_SIZE)) begin
      kind_cur = SK_CHAIN;
    end else begin
      kind_cur = SK_CROSS;
    end
  end

  // new shortcut for the entry being rebuilt
  always_comb begin
    sc_wdata.exit_pos = i_r;
    sc_wdata.jumps    = JUMPS_W'(1);
    sc_wdata.next_pos = POS_W'(v_r);
    case (kind_r)
      SK_EXIT: begin
        if (v_r > V_W'(MAX_HOLES)) begin
          sc_wdata.next_pos = POS_W'(MAX_HOLES);
        end
      end
      SK_CHAIN: begin
        sc_wdata.exit_pos = sc_q.exit_pos;
        sc_wdata.jumps    = sc_q.jumps + 1'b1;
        sc_wdata.next_pos = sc_q.next_pos;
      end
      default: begin
      end
    endcase
  end

  // saturating jump total and walk continuation
  assign sum_ext   = (FIELD_W + 1)'(sum_r) + (FIELD_W + 1)'(sc_q.jumps);
  assign sum_sat   = (sum_ext > (FIELD_W + 1)'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX)
                                                          : sum_ext[FIELD_W-1:0];
  assign walk_more = (sc_q.next_pos < n_eff) &&
                     (steps_r != STEP_W'(MAX_HOLES - 1));

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    str_nxt       = str_r;
    first_nxt     = first_r;
    v_nxt         = v_r;
    kind_nxt      = kind_r;
    sum_nxt       = sum_r;
    steps_nxt     = steps_r;
    res_last_nxt  = res_last_r;
    res_jumps_nxt = res_jumps_r;
    cmd_ready     = 1'b0;
    str_we        = 1'b0;
    str_waddr     = cmd_addr;
    str_wdata     = cmd.str;
    str_raddr     = i_r - 1'b1;
    sc_we         = 1'b0;
    sc_waddr      = i_r;
    sc_raddr      = cmd_addr;
    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_SET: begin
              str_we    = 1'b1;
              i_nxt     = cmd_addr;
              str_nxt   = cmd.str;
              first_nxt = 1'b1;
              state_nxt = S_RB_A;
            end
            OP_QUERY: begin
              sc_raddr  = cmd_addr;
              sum_nxt   = '0;
              steps_nxt = '0;
              state_nxt = S_QRUN;
            end
            default: begin
              res_last_nxt  = cmd.pos;
              res_jumps_nxt = '0;
              state_nxt     = S_DONE;
            end
          endcase
        end
      end
      S_RB_A: begin
        sc_raddr  = v_cur[ADDR_W-1:0];
        v_nxt     = v_cur;
        kind_nxt  = kind_cur;
        state_nxt = S_RB_B;
      end
      S_RB_B: begin
        sc_we = 1'b1;
        if ((i_r % BLOCK_SIZE) == '0) begin
          state_nxt = S_IDLE;
        end else begin
          i_nxt     = i_r - 1'b1;
          first_nxt = 1'b0;
          state_nxt = S_RB_A;
        end
      end
      S_QRUN: begin
        sum_nxt   = sum_sat;
        steps_nxt = steps_r + 1'b1;
        if (walk_more) begin
          sc_raddr = sc_q.next_pos[ADDR_W-1:0];
        end else begin
          res_last_nxt  = FIELD_W'(POS_W'(sc_q.exit_pos) + 1'b1);
          res_jumps_nxt = sum_sat;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    str_r       <= str_nxt;
    first_r     <= first_nxt;
    v_r         <= v_nxt;
    kind_r      <= kind_nxt;
    sum_r       <= sum_nxt;
    steps_r     <= steps_nxt;
    res_last_r  <= res_last_nxt;
    res_jumps_r <= res_jumps_nxt;
    if (out_load) begin
      out_last_r  <= res_last_r;
      out_jumps_r <= res_jumps_r;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.last_hole  = out_last_r;
  assign out_chan.jump_count = out_jumps_r;

`ifndef SYNTHESIS
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QRUN) |-> (steps_r < STEP_W'(MAX_HOLES)))
    else $error("query walk beyond shortcut limit");
`endif

`ifndef SYNTHESIS
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("finished query not presented");
`endif

`ifndef SYNTHESIS
  a_chain_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RB_B && kind_r == SK_CHAIN) |-> (v_r > V_W'(i_r)))
    else $error("chained shortcut does not point forward");
`endif

`ifndef SYNTHESIS
  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |=> (state_r != S_IDLE))
    else $error("accepted command left no work");
`endif

endmodule
